[rtl/core/rgba_downscale_3to2_macros.svh]
// assertion macros shared by the downscaler rtl
`ifndef RGBA_DOWNSCALE_3TO2_MACROS_SVH
`define RGBA_DOWNSCALE_3TO2_MACROS_SVH

// same-cycle implication, checked outside reset
`define RDS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define RDS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/rds_pkg.sv]
// shared types, constants and lane averaging functions of the 3:2 downscaler
`default_nettype none

package rds_pkg;

  localparam int RDS_MAX_WIDTH = 2048;

  localparam int PIX_W  = 32;
  localparam int ADDR_W = 24;
  localparam int CFG_W  = 13;
  localparam int SW_W   = 12;
  localparam int SH_W   = 12;
  localparam int DW_W   = 13;

  localparam logic [SW_W-1:0] SRC_WIDTH_RST  = 12'd384;
  localparam logic [SH_W-1:0] SRC_HEIGHT_RST = 12'd240;
  localparam logic [DW_W-1:0] DST_WIDTH_RST  = 13'd256;

  typedef enum logic [1:0] {
    CFG_SRC_WIDTH  = 2'd0,
    CFG_SRC_HEIGHT = 2'd1,
    CFG_DST_WIDTH  = 2'd2
  } cfg_idx_t;

  // position inside a column triple or a row band
  typedef enum logic [1:0] {
    PH_HEAD = 2'd0,
    PH_MID  = 2'd1,
    PH_TAIL = 2'd2
  } phase_t;

  typedef struct packed {
    logic              emit;
    logic              last;
    logic              store_we;
    logic              store_re;
    phase_t            col_ph;
    phase_t            row_ph;
    logic [ADDR_W-1:0] addr;
  } scan_ctl_t;

  function automatic logic [PIX_W-1:0] mean_two(input logic [PIX_W-1:0] p,
                                                 input logic [PIX_W-1:0] q);
    logic [PIX_W-1:0] res;
    logic [8:0]       sum;
    res = '0;
    for (int i = 0; i < 4; i++) begin
      sum = {1'b0, p[i*8 +: 8]} + {1'b0, q[i*8 +: 8]};
      res[i*8 +: 8] = sum[8:1];
    end
    return res;
  endfunction

  function automatic logic [PIX_W-1:0] mean_four(input logic [PIX_W-1:0] p,
                                                  input logic [PIX_W-1:0] q,
                                                  input logic [PIX_W-1:0] r,
                                                  input logic [PIX_W-1:0] s);
    logic [PIX_W-1:0] res;
    logic [9:0]       sum;
    res = '0;
    for (int i = 0; i < 4; i++) begin
      sum = {2'b00, p[i*8 +: 8]} + {2'b00, q[i*8 +: 8]} +
            {2'b00, r[i*8 +: 8]} + {2'b00, s[i*8 +: 8]};
      res[i*8 +: 8] = sum[9:2];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

[rtl/core/rds_ram.sv]
// generic single write port ram with registered read
`default_nettype none

module rds_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[rtl/core/rds_scan.sv]
// raster position counters, block phases and destination address generation
`default_nettype none

`include "rgba_downscale_3to2_macros.svh"

module rds_scan
  import rds_pkg::*;
#(
  parameter int MAX_WIDTH = RDS_MAX_WIDTH
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         step,
  input  wire logic [SW_W-1:0]              src_width,
  input  wire logic [SH_W-1:0]              src_height,
  input  wire logic [DW_W-1:0]              dst_width,
  output scan_ctl_t                         ctl,
  output logic      [$clog2(MAX_WIDTH)-1:0] col
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int EW = (CW + 3 > SW_W + 1) ? CW + 3 : SW_W + 1;
  localparam int RW = SH_W + 1;

  logic [CW-1:0]     c_r, c_nxt;
  logic [CW-1:0]     tstart_r, tstart_nxt;
  logic [CW:0]       ocol_r, ocol_nxt;
  phase_t            pc_r, pc_nxt;
  logic [SH_W-1:0]   r_r, r_nxt;
  logic [SH_W-1:0]   rstart_r, rstart_nxt;
  phase_t            pr_r, pr_nxt;
  logic [ADDR_W-1:0] base_r, base_nxt;

  logic [EW-1:0]     w_raw, w_eff;
  logic [RW-1:0]     h_eff;
  logic              col_full, row_full, col_end, row_end_blk;
  logic              row_end, frame_end;
  logic [ADDR_W-1:0] row_off;

  // width 0 counts as 1, widths past the line buffer saturate
  assign w_raw = EW'(src_width);
  always_comb begin
    if (w_raw == '0) begin
      w_eff = EW'(1);
    end else if (w_raw > EW'(MAX_WIDTH)) begin
      w_eff = EW'(MAX_WIDTH);
    end else begin
      w_eff = w_raw;
    end
  end
  assign h_eff = (src_height == '0) ? RW'(1) : RW'(src_height);

  assign col_full    = (EW'(tstart_r) + EW'(3)) <= w_eff;
  assign row_full    = (RW'(rstart_r) + RW'(3)) <= h_eff;
  assign col_end     = (EW'(tstart_r) + EW'(6)) > w_eff;
  assign row_end_blk = (RW'(rstart_r) + RW'(6)) > h_eff;
  assign row_end     = (EW'(c_r) + EW'(1)) >= w_eff;
  assign frame_end   = row_end && ((RW'(r_r) + RW'(1)) >= h_eff);

  assign row_off = (pr_r == PH_HEAD) ? '0 : ADDR_W'(dst_width);

  always_comb begin
    ctl.col_ph   = pc_r;
    ctl.row_ph   = pr_r;
    ctl.store_we = (pr_r == PH_MID);
    ctl.store_re = (pr_r == PH_TAIL);
    ctl.emit     = (pr_r != PH_MID) && (pc_r != PH_MID) && col_full && row_full;
    ctl.last     = ctl.emit && (pc_r == PH_TAIL) && (pr_r == PH_TAIL) &&
                   col_end && row_end_blk;
    ctl.addr     = base_r + row_off + ADDR_W'(ocol_r) + ADDR_W'(pc_r == PH_TAIL);
  end
  assign col = c_r;

  always_comb begin
    c_nxt      = c_r;
    tstart_nxt = tstart_r;
    ocol_nxt   = ocol_r;
    pc_nxt     = pc_r;
    r_nxt      = r_r;
    rstart_nxt = rstart_r;
    pr_nxt     = pr_r;
    base_nxt   = base_r;
    if (step) begin
      if (row_end) begin
        c_nxt      = '0;
        tstart_nxt = '0;
        ocol_nxt   = '0;
        pc_nxt     = PH_HEAD;
        if (frame_end) begin
          r_nxt      = '0;
          rstart_nxt = '0;
          pr_nxt     = PH_HEAD;
          base_nxt   = '0;
        end else begin
          r_nxt = r_r + 1'b1;
          unique case (pr_r)
            PH_HEAD: pr_nxt = PH_MID;
            PH_MID:  pr_nxt = PH_TAIL;
            PH_TAIL: begin
              pr_nxt     = PH_HEAD;
              rstart_nxt = rstart_r + SH_W'(3);
              base_nxt   = base_r + ADDR_W'({dst_width, 1'b0});
            end
            default: pr_nxt = PH_HEAD;
          endcase
        end
      end else begin
        c_nxt = c_r + 1'b1;
        unique case (pc_r)
          PH_HEAD: pc_nxt = PH_MID;
          PH_MID:  pc_nxt = PH_TAIL;
          PH_TAIL: begin
            pc_nxt     = PH_HEAD;
            tstart_nxt = tstart_r + CW'(3);
            ocol_nxt   = ocol_r + (CW+1)'(2);
          end
          default: pc_nxt = PH_HEAD;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_r      <= '0;
      tstart_r <= '0;
      ocol_r   <= '0;
      pc_r     <= PH_HEAD;
      r_r      <= '0;
      rstart_r <= '0;
      pr_r     <= PH_HEAD;
      base_r   <= '0;
    end else begin
      c_r      <= c_nxt;
      tstart_r <= tstart_nxt;
      ocol_r   <= ocol_nxt;
      pc_r     <= pc_nxt;
      r_r      <= r_nxt;
      rstart_r <= rstart_nxt;
      pr_r     <= pr_nxt;
      base_r   <= base_nxt;
    end
  end

  // triple start plus phase must track the column counter
  `RDS_ASSERT_NOW(a_col_phase_track, 1'b1,
    ((CW+1)'(tstart_r) + (CW+1)'(pc_r)) == (CW+1)'(c_r), "column phase out of step")
  // band start plus phase must track the row counter
  `RDS_ASSERT_NOW(a_row_phase_track, 1'b1,
    (RW'(rstart_r) + RW'(pr_r)) == RW'(r_r), "row phase out of step")

endmodule

`default_nettype wire

[rtl/core/rds_mix.sv]
// per-lane averaging that forms one destination pixel from its source taps
`default_nettype none

module rds_mix
  import rds_pkg::*;
(
  input  wire phase_t            col_ph,
  input  wire phase_t            row_ph,
  input  wire logic [PIX_W-1:0]  pix,
  input  wire logic [PIX_W-1:0]  held,
  input  wire logic [PIX_W-1:0]  store_cur,
  input  wire logic [PIX_W-1:0]  store_prev,
  output logic      [PIX_W-1:0]  pix_out
);

  always_comb begin
    if (row_ph == PH_HEAD) begin
      // top row of the block
      pix_out = (col_ph == PH_TAIL) ? mean_two(held, pix) : pix;
    end else begin
      // bottom row, mixes in the buffered middle row
      pix_out = (col_ph == PH_TAIL) ? mean_four(store_prev, store_cur, held, pix)
                                    : mean_two(store_cur, pix);
    end
  end

endmodule

`default_nettype wire

[rtl/core/rgba_downscale_3to2.sv]
// top level of the streaming 3:2 rgba box downscaler
// an accepted word is registered in stage 1, then in the output register that drives out_valid
// throughput: one word per cycle, sustained, while out_stall stays low
// the rate is set by the line buffer, one write or one registered read per word
// reset: synchronous active-low, clears counters and valid flags, restores
// register defaults; the line buffer is not cleared and needs no warm-up pass
`default_nettype none

`include "rgba_downscale_3to2_macros.svh"

module rgba_downscale_3to2
  import rds_pkg::*;
#(
  parameter int MAX_WIDTH = RDS_MAX_WIDTH
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  // configuration write port
  input  wire logic              cfg_we,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [CFG_W-1:0]  cfg_data,
  // source pixel channel
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [PIX_W-1:0]  in_pixel_in,
  // destination pixel channel
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic      [PIX_W-1:0]  out_pixel_out,
  output logic      [ADDR_W-1:0] out_dst_address,
  output logic                   out_frame_last
);

  localparam int CW = $clog2(MAX_WIDTH);

  // configuration registers
  logic [SW_W-1:0] src_width_r;
  logic [SH_W-1:0] src_height_r;
  logic [DW_W-1:0] dst_width_r;

  // scan control for the word at the input
  scan_ctl_t       ctl;
  logic [CW-1:0]   col;
  logic            in_acc;

  // held pixel: the middle word of the current column triple
  logic [PIX_W-1:0] held_r;

  // line buffer read data and the entry read one word earlier
  logic [PIX_W-1:0] store_q;
  logic [PIX_W-1:0] store_prev_r;

  // stage 1: accepted word that will produce a result
  logic              s1_v_r;
  logic [PIX_W-1:0]  s1_pix_r;
  logic [PIX_W-1:0]  s1_held_r;
  phase_t            s1_col_ph_r;
  phase_t            s1_row_ph_r;
  logic [ADDR_W-1:0] s1_addr_r;
  logic              s1_last_r;
  logic [PIX_W-1:0]  mix_pix;

  // output register
  logic              out_valid_r;
  logic [PIX_W-1:0]  out_pix_r;
  logic [ADDR_W-1:0] out_addr_r;
  logic              out_last_r;
  logic              out_load;

  // config writes; an unknown index is dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_width_r  <= SRC_WIDTH_RST;
      src_height_r <= SRC_HEIGHT_RST;
      dst_width_r  <= DST_WIDTH_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SRC_WIDTH:  src_width_r  <= cfg_data[SW_W-1:0];
        CFG_SRC_HEIGHT: src_height_r <= cfg_data[SH_W-1:0];
        CFG_DST_WIDTH:  dst_width_r  <= cfg_data[DW_W-1:0];
        default: ;
      endcase
    end
  end

  // handshake: stage 1 moves on whenever the output register is free or draining,
  // so the input only stalls when both stages are full and the sink stalls
  assign out_load = s1_v_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_v_r && out_valid_r && out_stall;
  assign in_acc   = in_valid && !in_stall;

  rds_scan #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (in_acc),
    .src_width  (src_width_r),
    .src_height (src_height_r),
    .dst_width  (dst_width_r),
    .ctl        (ctl),
    .col        (col)
  );

  // middle row of each band is written, bottom row reads it back by column;
  // reads only fire on accept so the data holds while stage 1 stalls
  rds_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_buf (
    .clk   (clk),
    .we    (in_acc && ctl.store_we),
    .waddr (col),
    .wdata (in_pixel_in),
    .re    (in_acc && ctl.store_re),
    .raddr (col),
    .rdata (store_q)
  );

  // the previous bottom-row read is the left neighbor of the block's tail column
  always_ff @(posedge clk) begin
    if (in_acc && ctl.store_re) begin
      store_prev_r <= store_q;
    end
  end

  // capture the middle word of a triple on the top and bottom rows
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= '0;
    end else if (in_acc && ctl.col_ph == PH_MID && ctl.row_ph != PH_MID) begin
      held_r <= in_pixel_in;
    end
  end

  // stage 1 register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_acc) begin
      s1_v_r <= ctl.emit;
    end else if (out_load) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_pix_r    <= in_pixel_in;
      s1_held_r   <= held_r;
      s1_col_ph_r <= ctl.col_ph;
      s1_row_ph_r <= ctl.row_ph;
      s1_addr_r   <= ctl.addr;
      s1_last_r   <= ctl.last;
    end
  end

  rds_mix u_mix (
    .col_ph     (s1_col_ph_r),
    .row_ph     (s1_row_ph_r),
    .pix        (s1_pix_r),
    .held       (s1_held_r),
    .store_cur  (store_q),
    .store_prev (store_prev_r),
    .pix_out    (mix_pix)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_pix_r  <= mix_pix;
      out_addr_r <= s1_addr_r;
      out_last_r <= s1_last_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pixel_out   = out_pix_r;
  assign out_dst_address = out_addr_r;
  assign out_frame_last  = out_last_r;

  // a word that produces a result must land in stage 1
  `RDS_ASSERT_NEXT(a_emit_to_s1, in_acc && ctl.emit, s1_v_r, "result word lost at stage 1")
  // a stage 1 transfer shows up at the output with its address
  `RDS_ASSERT_NEXT(a_s1_to_out, out_load,
    out_valid_r && (out_addr_r == $past(s1_addr_r)), "stage 1 transfer lost")
  // the line buffer is never written and read for the same word
  `RDS_ASSERT_NOW(a_buf_port_excl, in_acc && ctl.store_we, !ctl.store_re,
    "line buffer write and read in one word")

endmodule

`default_nettype wire

[tb/tb_rgba_downscale_3to2.sv]
// self-checking testbench for the 3:2 rgba box downscaler, directed table plus random frames
`timescale 1ns / 1ps

module tb_rgba_downscale_3to2;
  import rds_pkg::*;

  // one result word as it leaves the block
  typedef struct packed {
    logic [PIX_W-1:0]  pix;
    logic [ADDR_W-1:0] addr;
    logic              last;
  } dst_word_t;

  // one row of the directed table: a register write or a source word
  typedef struct packed {
    logic              is_cfg;
    cfg_idx_t          reg_sel;
    logic [CFG_W-1:0]  reg_val;
    logic [PIX_W-1:0]  px;
    logic              typed;
    dst_word_t         want;
  } dir_row_t;

  // even byte lanes of a packed pixel
  localparam logic [31:0] EVEN_LANES = 32'h00FF_00FF;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_we = 1'b0;
  cfg_idx_t          cfg_index = CFG_SRC_WIDTH;
  logic [CFG_W-1:0]  cfg_data = '0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [PIX_W-1:0]  in_pixel_in = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [PIX_W-1:0]  out_pixel_out;
  logic [ADDR_W-1:0] out_dst_address;
  logic              out_frame_last;

  // idle odds in percent, changed as the random part moves on
  int gap_pct = 23;
  int stall_pct = 63;

  // predictor copy of the block: registers, line buffer, held pixel, scan counters
  logic [SW_W-1:0]   src_w_q = SRC_WIDTH_RST;
  logic [SH_W-1:0]   src_h_q = SRC_HEIGHT_RST;
  logic [DW_W-1:0]   dst_w_q = DST_WIDTH_RST;
  logic [PIX_W-1:0]  row_one_line [RDS_MAX_WIDTH];
  bit                line_written [RDS_MAX_WIDTH];
  logic [PIX_W-1:0]  held_px = '0;
  logic [10:0]       col_cnt = '0;
  logic [11:0]       row_cnt = '0;
  logic [ADDR_W-1:0] band_base = '0;

  dst_word_t pending_dst_words [$];
  int        bad_words = 0;

  always #2 clk = ~clk;

  rgba_downscale_3to2 uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_pixel_in     (in_pixel_in),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_pixel_out   (out_pixel_out),
    .out_dst_address (out_dst_address),
    .out_frame_last  (out_frame_last)
  );

  // directed table builders
  function automatic dir_row_t cfg_row(input cfg_idx_t sel, input logic [CFG_W-1:0] val);
    dir_row_t row;
    row = '0;
    row.is_cfg = 1'b1;
    row.reg_sel = sel;
    row.reg_val = val;
    return row;
  endfunction

  function automatic dir_row_t px_row(input logic [PIX_W-1:0] p);
    dir_row_t row;
    row = '0;
    row.px = p;
    return row;
  endfunction

  // source word whose result is obvious enough to type in
  function automatic dir_row_t px_chk(input logic [PIX_W-1:0] p, input logic [PIX_W-1:0] pix,
                                      input logic [ADDR_W-1:0] addr, input logic last);
    dir_row_t row;
    row = px_row(p);
    row.typed = 1'b1;
    row.want = '{pix, addr, last};
    return row;
  endfunction

  localparam int DIR_LEN = 36;
  localparam dir_row_t DIR_ROWS [DIR_LEN] = '{
    // reset geometry: top-left passes through, top-right is the mean of the middle and right words
    px_chk(32'hFFFF_FFFF, 32'hFFFF_FFFF, 24'd0, 1'b0),
    px_row(32'hFFFF_FFFF),
    px_chk(32'h0000_0000, 32'h7F7F_7F7F, 24'd1, 1'b0),
    // shrink to 3x3 mid-row: column 3 is past the new row end, so it just closes row 0
    cfg_row(CFG_SRC_WIDTH, 13'd3),
    cfg_row(CFG_SRC_HEIGHT, 13'd3),
    cfg_row(CFG_DST_WIDTH, 13'd5),
    px_row(32'hA5A5_A5A5),
    // row 1 goes to the line buffer
    px_row(32'h0000_0000),
    px_row(32'hFFFF_FFFF),
    px_row(32'hFFFF_FFFF),
    // row 2: bottom-left and bottom-right, odd stride, last word of the frame
    px_chk(32'hFFFF_FFFF, 32'h7F7F_7F7F, 24'd5, 1'b0),
    px_row(32'hFFFF_FFFF),
    px_chk(32'hFFFF_FFFF, 32'hFFFF_FFFF, 24'd6, 1'b1),
    // zero width and height act as one, zero stride
    cfg_row(CFG_SRC_WIDTH, 13'd0),
    cfg_row(CFG_SRC_HEIGHT, 13'd0),
    cfg_row(CFG_DST_WIDTH, 13'd0),
    px_row(32'h5A5A_5A5A),
    // 4x4 frame: partial triple in column 3, partial band in row 3, widest stride
    cfg_row(CFG_SRC_WIDTH, 13'd4),
    cfg_row(CFG_SRC_HEIGHT, 13'd4),
    cfg_row(CFG_DST_WIDTH, 13'd8191),
    px_row(32'h0123_4567), px_row(32'h89AB_CDEF), px_row(32'hFEDC_BA98), px_row(32'h7654_3210),
    px_row(32'hFF00_FF00), px_row(32'h00FF_00FF), px_row(32'h8080_8080), px_row(32'h7F7F_7F7F),
    px_row(32'h0101_0101), px_row(32'hFEFE_FEFE), px_row(32'hFFFF_FFFF), px_row(32'h0000_0000),
    px_row(32'h0F0F_0F0F), px_row(32'hF0F0_F0F0), px_row(32'h5555_5555), px_row(32'hAAAA_AAAA)
  };

  // per-lane means, truncated; two lanes at a time through the even-lane mask
  function automatic logic [31:0] lane_avg2(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] lo, hi;
    lo = (a & EVEN_LANES) + (b & EVEN_LANES);
    hi = ((a >> 8) & EVEN_LANES) + ((b >> 8) & EVEN_LANES);
    return ((lo >> 1) & EVEN_LANES) | (((hi >> 1) & EVEN_LANES) << 8);
  endfunction

  function automatic logic [31:0] lane_avg4(input logic [31:0] a, input logic [31:0] b,
                                            input logic [31:0] c, input logic [31:0] d);
    logic [31:0] lo, hi;
    lo = (a & EVEN_LANES) + (b & EVEN_LANES) + (c & EVEN_LANES) + (d & EVEN_LANES);
    hi = ((a >> 8) & EVEN_LANES) + ((b >> 8) & EVEN_LANES) +
         ((c >> 8) & EVEN_LANES) + ((d >> 8) & EVEN_LANES);
    return ((lo >> 2) & EVEN_LANES) | (((hi >> 2) & EVEN_LANES) << 8);
  endfunction

  // width as the block uses it: zero acts as one, saturated at the line buffer size
  function automatic int eff_width();
    int w;
    w = int'(src_w_q);
    if (w == 0) w = 1;
    if (w > RDS_MAX_WIDTH) w = RDS_MAX_WIDTH;
    return w;
  endfunction

  function automatic int eff_height();
    return (src_h_q == '0) ? 1 : int'(src_h_q);
  endfunction

  // the next source word would average a line buffer entry never written since reset
  function automatic bit hits_unwritten();
    int w, h, c, r;
    bit full;
    w = eff_width();
    h = eff_height();
    c = int'(col_cnt);
    r = int'(row_cnt);
    full = (c - (c % 3) + 3 <= w) && (r - (r % 3) + 3 <= h);
    if (r % 3 != 2 || c % 3 == 1 || !full) return 1'b0;
    return !line_written[c] || (c % 3 == 2 && !line_written[c-1]);
  endfunction

  // advance the scan by one source word; returns 1 when a destination word comes out
  function automatic bit downscale_pixel(input logic [PIX_W-1:0] px, output dst_word_t word);
    int          w, h, c, r, ocol;
    phase_t      col_ph, row_ph;
    bit          full, at_end, hit;
    logic [31:0] rowoff, addr;
    w = eff_width();
    h = eff_height();
    c = int'(col_cnt);
    r = int'(row_cnt);
    col_ph = phase_t'(c % 3);
    row_ph = phase_t'(r % 3);
    ocol = 2 * (c / 3);
    // only whole 3x3 blocks produce output
    full = (c - (c % 3) + 3 <= w) && (r - (r % 3) + 3 <= h);
    at_end = (r == (h / 3) * 3 - 1) && (c == (w / 3) * 3 - 1);
    hit = 1'b0;
    word = '0;
    if (row_ph == PH_MID) begin
      row_one_line[c] = px;
      line_written[c] = 1'b1;
    end else begin
      rowoff = (row_ph == PH_HEAD) ? 32'd0 : 32'(dst_w_q);
      if (col_ph == PH_MID) begin
        held_px = px;
      end else if (full) begin
        if (col_ph == PH_HEAD) begin
          word.pix = (row_ph == PH_HEAD) ? px : lane_avg2(row_one_line[c], px);
          addr = 32'(band_base) + rowoff + 32'(ocol);
        end else begin
          word.pix = (row_ph == PH_HEAD) ? lane_avg2(held_px, px) :
                     lane_avg4(row_one_line[c-1], row_one_line[c], held_px, px);
          addr = 32'(band_base) + rowoff + 32'(ocol) + 32'd1;
        end
        word.addr = addr[ADDR_W-1:0];
        word.last = (col_ph == PH_TAIL) && (row_ph == PH_TAIL) && at_end;
        hit = 1'b1;
      end
    end
    // counters wrap at row and frame ends; band base steps two destination rows per band
    if (c + 1 >= w) begin
      col_cnt = '0;
      if (r + 1 >= h) begin
        row_cnt = '0;
        band_base = '0;
      end else begin
        if (row_ph == PH_TAIL) band_base = ADDR_W'(32'(band_base) + 2 * 32'(dst_w_q));
        row_cnt = 12'(r + 1);
      end
    end else begin
      col_cnt = 11'(c + 1);
    end
    return hit;
  endfunction

  function automatic logic [PIX_W-1:0] rand_pixel();
    case ($urandom_range(5))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  // hand one source word over, then log what it should produce
  task automatic send_pixel(input logic [PIX_W-1:0] px, input logic typed = 1'b0,
                            input dst_word_t want = '0);
    dst_word_t word;
    bit        hit;
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_pixel_in <= px;
    do @(posedge clk); while (in_stall);
    hit = downscale_pixel(px, word);
    if (typed) pending_dst_words.push_back(want);
    else if (hit) pending_dst_words.push_back(word);
  endtask

  // let the block drain: input idle, wait until no words are in flight, then run on past the pipeline depth
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_dst_words.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic cfg_write(input cfg_idx_t sel, input logic [CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= sel;
    cfg_data <= val;
    @(posedge clk);
    case (sel)
      CFG_SRC_WIDTH:  src_w_q = val[SW_W-1:0];
      CFG_SRC_HEIGHT: src_h_q = val[SH_W-1:0];
      CFG_DST_WIDTH:  dst_w_q = val[DW_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
                            input logic [CFG_W-1:0] d);
    settle();
    cfg_write(CFG_SRC_WIDTH, w);
    cfg_write(CFG_SRC_HEIGHT, h);
    cfg_write(CFG_DST_WIDTH, d);
    cfg_we <= 1'b0;
  endtask

  // receiver backpressure
  always @(posedge clk) out_stall <= ($urandom_range(99) < stall_pct);

  // compare every accepted result word with the oldest one logged
  always @(posedge clk) begin
    dst_word_t want, got;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_pixel_out, out_dst_address, out_frame_last};
      if (pending_dst_words.size() == 0) begin
        bad_words++;
        $display("%0t: unexpected word: exp none, got pixel_out %h dst_address %h frame_last %b",
                 $time, got.pix, got.addr, got.last);
      end else begin
        want = pending_dst_words.pop_front();
        if (want.pix !== got.pix || want.addr !== got.addr || want.last !== got.last) begin
          bad_words++;
          $display("%0t: word differs: pixel_out exp %h got %h, dst_address exp %h got %h,%s",
                   $time, want.pix, got.pix, want.addr, got.addr,
                   $sformatf(" frame_last exp %b got %b", want.last, got.last));
        end
      end
    end
  end

  initial begin
    int  w, h, d, ew, eh, left, n, loose_words;
    bit  cfg_open;
    cfg_open = 1'b0;
    loose_words = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed table; register rows are written back to back once the block is idle
    for (int i = 0; i < DIR_LEN; i++) begin
      if (DIR_ROWS[i].is_cfg) begin
        if (!cfg_open) settle();
        cfg_write(DIR_ROWS[i].reg_sel, DIR_ROWS[i].reg_val);
        cfg_open = 1'b1;
      end else begin
        if (cfg_open) cfg_we <= 1'b0;
        cfg_open = 1'b0;
        send_pixel(DIR_ROWS[i].px, DIR_ROWS[i].typed, DIR_ROWS[i].want);
      end
    end

    // random geometries; most phases run to a frame end, the rest stop mid-frame;
    // a phase also stops before a word that would average a never-written buffer slot
    while (loose_words < 1350) begin
      if (loose_words >= 900) begin
        gap_pct = 0;
        stall_pct = 0;
      end else if (loose_words >= 450) begin
        gap_pct = 63;
        stall_pct = 23;
      end
      case ($urandom_range(9))
        0: w = 0;
        1: w = $urandom_range(2040, 4095);
        default: w = $urandom_range(1, 24);
      endcase
      case ($urandom_range(9))
        0: h = 0;
        1: h = 4095;
        default: h = $urandom_range(1, 12);
      endcase
      case ($urandom_range(9))
        0: d = 0;
        1: d = 8191;
        2: d = $urandom_range(8191);
        default: d = $urandom_range(1, 40);
      endcase
      // bit 12 of the data word is dropped for the 12-bit registers
      set_config({1'($urandom_range(1)), 12'(w)}, {1'($urandom_range(1)), 12'(h)}, 13'(d));
      ew = eff_width();
      eh = eff_height();
      left = ((int'(col_cnt) + 1 >= ew) ? 1 : ew - int'(col_cnt)) +
             ((int'(row_cnt) + 1 >= eh) ? 0 : (eh - 1 - int'(row_cnt)) * ew);
      if (left + ew * eh <= 400 && $urandom_range(9) < 7)
        n = left + ($urandom_range(1) ? ew * eh : 0);
      else
        n = $urandom_range(1, 60);
      repeat (n) begin
        if (hits_unwritten()) break;
        send_pixel(rand_pixel());
        loose_words++;
      end
    end

    settle();
    if (bad_words == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

[files.f]
+incdir+rtl/core
rtl/core/rds_pkg.sv
rtl/core/rds_ram.sv
rtl/core/rds_scan.sv
rtl/core/rds_mix.sv
rtl/core/rgba_downscale_3to2.sv
tb/tb_rgba_downscale_3to2.sv
